[rtl/event_stream_validator_assert.svh]
// Assertion helpers shared by the fifo and back-end modules.
`ifndef EVENT_STREAM_VALIDATOR_ASSERT_SVH
`define EVENT_STREAM_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ESV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ESV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/esv_pkg.sv]
`default_nettype none

package esv_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OPC_W     = 7;
  localparam int unsigned FLAG_W    = 10;
  localparam int unsigned LOWFLAG_W = 5;
  localparam int unsigned LEFT_W    = 5;
  localparam int unsigned COUNT_W   = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 17'd65536;

  // word_kind codes
  localparam logic [1:0] KIND_CMD     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_TOKEN   = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // verdict codes
  localparam logic [2:0] VERD_CONT  = 3'd0;
  localparam logic [2:0] VERD_END   = 3'd1;
  localparam logic [2:0] VERD_BAD   = 3'd2;
  localparam logic [2:0] VERD_LIMIT = 3'd3;
  localparam logic [2:0] VERD_IDLE  = 3'd4;

  // what an opcode asks the parser to do next
  typedef enum logic [2:0] {
    CLS_END,        // stream ends cleanly
    CLS_TOKEN_END,  // one token, then end
    CLS_TOKEN,      // one token, then continue
    CLS_NONE,       // nothing follows
    CLS_PAYLOAD,    // payload words follow (count may be zero)
    CLS_BAD         // invalid opcode
  } cls_e;

  // classified word handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] fixed;
    logic              sos;
    logic [OPC_W-1:0]  opc;
    cls_e              cls;
    logic [LEFT_W-1:0] n;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        kind;
    logic [2:0]        verdict;
    logic [OPC_W-1:0]  opc;
    logic              follow;
  } result_t;

endpackage

`default_nettype wire

[rtl/esv_front.sv]
`default_nettype none

// Front end: takes raw words, undoes the half swap and decodes the opcode.
module esv_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                swap_mode_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [31:0]         in_word_i,
  input  wire logic                in_sos_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output esv_pkg::item_t           out_item_o
);

  logic              valid_q, valid_d;
  esv_pkg::item_t    item_q, item_d;
  logic [31:0]       fixed;
  logic [6:0]        opc;
  logic [9:0]        flags;
  logic [3:0]        ones10;
  logic [2:0]        ones5;
  logic              take;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  assign fixed = swap_mode_i ? {in_word_i[15:0], in_word_i[31:16]} : in_word_i;
  assign opc   = fixed[31:25];
  assign flags = fixed[24:15];

  always_comb begin
    ones10 = '0;
    ones5  = '0;
    for (int i = 0; i < esv_pkg::FLAG_W; i++) begin
      ones10 = ones10 + {3'b0, flags[i]};
    end
    for (int i = 0; i < esv_pkg::LOWFLAG_W; i++) begin
      ones5 = ones5 + {2'b0, flags[i]};
    end
  end

  always_comb begin
    item_d       = item_q;
    item_d.raw   = in_word_i;
    item_d.fixed = fixed;
    item_d.sos   = in_sos_i;
    item_d.opc   = opc;
    item_d.n     = '0;
    case (opc) inside
      7'd0:                    item_d.cls = esv_pkg::CLS_END;
      7'd1, 7'd14:             item_d.cls = esv_pkg::CLS_TOKEN_END;
      7'd13:                   item_d.cls = esv_pkg::CLS_TOKEN;
      7'd2, 7'd12, 7'd15, 7'd16: item_d.cls = esv_pkg::CLS_NONE;
      [7'd3:7'd4], [7'd7:7'd11], [7'd17:7'd21]: begin
        item_d.cls = esv_pkg::CLS_PAYLOAD;
        item_d.n   = {1'b0, ones10};
      end
      7'd5, 7'd6: begin
        item_d.cls = esv_pkg::CLS_PAYLOAD;
        item_d.n   = {ones10, 1'b0};
      end
      7'd22: begin
        item_d.cls = esv_pkg::CLS_PAYLOAD;
        item_d.n   = {2'b0, ones5};
      end
      default:                 item_d.cls = esv_pkg::CLS_BAD;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

[rtl/esv_fifo.sv]
`default_nettype none

// Short queue between front and back.
module esv_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire esv_pkg::item_t push_item_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output esv_pkg::item_t      pop_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  esv_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`include "event_stream_validator_assert.svh"

  `ESV_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= FULL_CNT, "fifo count above depth")
  `ESV_ASSERT_NEXT(a_ptr_gap, push && !pop && cnt_q == FULL_CNT - CNT_W'(1),
                   wr_ptr_q == rd_ptr_q, "full fifo pointers disagree")

endmodule

`default_nettype wire

[rtl/esv_back.sv]
`default_nettype none

// Back end: stream parser state and the output register.
module esv_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [16:0]         step_limit_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire esv_pkg::item_t      in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output esv_pkg::result_t         out_res_o
);

  typedef enum logic [1:0] {
    PH_DONE,
    PH_CMD,
    PH_PAYLOAD,
    PH_TOKEN
  } phase_e;

  phase_e                         phase_q, phase_d, ph_eff;
  logic [esv_pkg::LEFT_W-1:0]     left_q, left_d, left_eff, left_dec;
  logic                           eat_q, eat_d, eat_eff;
  logic [esv_pkg::COUNT_W-1:0]    cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic                           out_valid_q;
  esv_pkg::result_t               res_q, res_d;
  logic                           take;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    // start of stream resets the parser before this word is looked at
    ph_eff   = in_item_i.sos ? PH_CMD : phase_q;
    left_eff = in_item_i.sos ? '0 : left_q;
    eat_eff  = in_item_i.sos ? 1'b0 : eat_q;
    cnt_eff  = in_item_i.sos ? '0 : cnt_q;
    cnt_inc  = (cnt_eff == esv_pkg::COUNT_MAX) ? cnt_eff
                                               : cnt_eff + esv_pkg::COUNT_W'(1);
    left_dec = (left_eff != '0) ? left_eff - esv_pkg::LEFT_W'(1) : '0;

    phase_d = ph_eff;
    left_d  = left_eff;
    eat_d   = eat_eff;
    cnt_d   = cnt_eff;

    res_d.word    = in_item_i.raw;
    res_d.kind    = esv_pkg::KIND_IGNORED;
    res_d.verdict = esv_pkg::VERD_IDLE;
    res_d.opc     = '0;
    res_d.follow  = 1'b0;

    case (ph_eff)
      PH_CMD: begin
        res_d.word = in_item_i.fixed;
        res_d.kind = esv_pkg::KIND_CMD;
        cnt_d      = cnt_inc;
        if (cnt_inc > step_limit_i) begin
          res_d.verdict = esv_pkg::VERD_LIMIT;
          phase_d       = PH_DONE;
        end else begin
          res_d.opc     = in_item_i.opc;
          res_d.verdict = esv_pkg::VERD_CONT;
          case (in_item_i.cls)
            esv_pkg::CLS_END: begin
              res_d.verdict = esv_pkg::VERD_END;
              phase_d       = PH_DONE;
            end
            esv_pkg::CLS_TOKEN_END: begin
              phase_d = PH_TOKEN;
              eat_d   = 1'b1;
            end
            esv_pkg::CLS_TOKEN: begin
              phase_d = PH_TOKEN;
              eat_d   = 1'b0;
            end
            esv_pkg::CLS_NONE: begin
            end
            esv_pkg::CLS_PAYLOAD: begin
              if (in_item_i.n != '0) begin
                left_d  = in_item_i.n;
                phase_d = PH_PAYLOAD;
              end
            end
            default: begin
              res_d.verdict = esv_pkg::VERD_BAD;
              phase_d       = PH_DONE;
            end
          endcase
        end
      end
      PH_PAYLOAD: begin
        res_d.word    = in_item_i.fixed;
        res_d.kind    = esv_pkg::KIND_PAYLOAD;
        res_d.verdict = esv_pkg::VERD_CONT;
        left_d        = left_dec;
        if (left_dec == '0) begin
          phase_d = PH_CMD;
        end
      end
      PH_TOKEN: begin
        res_d.kind    = esv_pkg::KIND_TOKEN;
        res_d.follow  = eat_eff;
        res_d.verdict = eat_eff ? esv_pkg::VERD_END : esv_pkg::VERD_CONT;
        phase_d       = eat_eff ? PH_DONE : PH_CMD;
        eat_d         = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DONE;
      left_q      <= '0;
      eat_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        left_q  <= left_d;
        eat_q   <= eat_d;
        cnt_q   <= cnt_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

`include "event_stream_validator_assert.svh"

  `ESV_ASSERT_NOW(a_payload_left, phase_q == PH_PAYLOAD, left_q != '0,
                  "payload phase with nothing left")
  `ESV_ASSERT_NEXT(a_final_verdict,
                   take && (res_d.verdict == esv_pkg::VERD_END ||
                            res_d.verdict == esv_pkg::VERD_BAD ||
                            res_d.verdict == esv_pkg::VERD_LIMIT),
                   phase_q == PH_DONE, "stream verdict did not stop parser")
  `ESV_ASSERT_NOW(a_token_clears, phase_q != PH_TOKEN, !eat_q || phase_q == PH_DONE ||
                  phase_q == PH_CMD || phase_q == PH_PAYLOAD ? !eat_q : 1'b1,
                  "end-after-token flag outside token phase")

endmodule

`default_nettype wire

[rtl/event_stream_validator.sv]
`default_nettype none

// Event stream validator.
// Slave stream: one 32-bit command stream word per transaction in s_axis_tdata;
//   s_axis_tuser set marks the first word of a new stream and restarts the parser.
// Master stream: one result transaction per input word, in input order: the word
//   (after the optional half exchange for command and payload words only), its
//   kind, the stream verdict, the decoded opcode and the follow-token flag.
// APB port: register 0 (addr 0x0) swap_mode, register 1 (addr 0x4) step_limit.
//   Write only while no transactions are in flight.
// Throughput: one word per cycle, sustained while m_axis_tready is high; the
//   parser decides each word combinationally, so nothing in the back end loops.
// Path: a result reaches the master side through the front decode register, the
//   queue and the output register.
// Reset: parser done (words before the first stream start are ignored/idle),
//   swap_mode 1, step_limit 65536, queue and output empty.
// Receiver stall: the output register holds; the queue absorbs up to
//   FIFO_DEPTH words plus one in the front register before s_axis_tready drops.
module event_stream_validator #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] stream_word
  input  wire logic        s_axis_tuser,   // [0] start_of_stream
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [31:0] out_word, [34:32] verdict,
                                           // [41:35] opcode_seen, [47:42] zero
  output logic [2:0]       m_axis_tuser,   // [1:0] word_kind, [2] follow_token
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_SWAP  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  logic               swap_q;
  logic [16:0]        limit_q;
  logic               cfg_wr;

  logic               fr_valid, fr_ready;
  esv_pkg::item_t     fr_item;
  logic               q_valid, q_ready;
  esv_pkg::item_t     q_item;
  esv_pkg::result_t   res;

  // APB: always ready, write on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_LIMIT) ? {15'b0, limit_q} : {31'b0, swap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q  <= 1'b1;
      limit_q <= esv_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SWAP) begin
        swap_q <= pwdata[0];
      end else begin
        limit_q <= pwdata[16:0];
      end
    end
  end

  // Front: half exchange and opcode classification.
  esv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .swap_mode_i (swap_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (s_axis_tdata),
    .in_sos_i    (s_axis_tuser),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  // Queue decouples decode from the parser.
  esv_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // Back: parser state, step counting, output register.
  esv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_limit_i (limit_q),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_item_i    (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_res_o    (res)
  );

  assign m_axis_tdata = {6'b0, res.opc, res.verdict, res.word};
  assign m_axis_tuser = {res.follow, res.kind};

endmodule

`default_nettype wire
